>>> src/qte_pkg.sv
// ---------------------------------------------------------------------------
// qte_pkg
// Shared types, constants and saturating arithmetic for the quartic
// trajectory evaluator.
// ---------------------------------------------------------------------------
package qte_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int NUM_CELLS = 4;
  localparam int ADDR_BITS = 5;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [2*WORD_BITS-1:0] prod_t;
  typedef logic signed [2*WORD_BITS:0] wide_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  localparam logic [1:0] KIND_POS    = 2'd0;
  localparam logic [1:0] KIND_FIRST  = 2'd1;
  localparam logic [1:0] KIND_SECOND = 2'd2;
  localparam logic [1:0] KIND_THIRD  = 2'd3;

  localparam logic [2:0] REG_START_POSITION = 3'd0;
  localparam logic [2:0] REG_START_VELOCITY = 3'd1;
  localparam logic [2:0] REG_START_ACCEL    = 3'd2;
  localparam logic [2:0] REG_END_VELOCITY   = 3'd3;
  localparam logic [2:0] REG_END_ACCEL      = 3'd4;
  localparam logic [2:0] REG_DURATION       = 3'd5;

  localparam logic [WORD_BITS-2:0] DURATION_RESET = (WORD_BITS-1)'(65536);

  typedef struct packed {
    logic [1:0] kind;
    word_t      time_point;
  } request_t;

  typedef struct packed {
    word_t value;
    logic  overflow;
  } result_t;

  typedef struct packed {
    word_t val;
    logic  ov;
  } sat_t;

  typedef struct packed {
    word_t                start_position;
    word_t                start_velocity;
    word_t                start_accel;
    word_t                end_velocity;
    word_t                end_accel;
    logic [WORD_BITS-2:0] duration;
  } cfg_t;

  typedef struct packed {
    word_t a0;
    word_t a1;
    word_t a2;
    word_t a3;
    word_t a4;
    word_t a2x2;
    word_t a3x3;
    word_t a3x6;
    word_t a4x4;
    word_t a4x12;
    word_t a4x24;
    logic  ov_first;
    logic  ov_second;
    logic  ov_third;
  } coef_t;

  typedef struct packed {
    logic [1:0] kind;
    word_t      t;
    word_t      r;
    logic       ov;
  } stage_t;

  function automatic sat_t sat_wide(wide_t x);
    sat_t s;
    s.ov  = 1'b1;
    s.val = word_t'(x);
    if (x > wide_t'(WORD_MAX)) begin
      s.val = WORD_MAX;
    end else if (x < wide_t'(WORD_MIN)) begin
      s.val = WORD_MIN;
    end else begin
      s.ov = 1'b0;
    end
    return s;
  endfunction

  function automatic sat_t sat_add(word_t a, word_t b);
    return sat_wide(wide_t'(a) + wide_t'(b));
  endfunction

  function automatic sat_t sat_sub(word_t a, word_t b);
    return sat_wide(wide_t'(a) - wide_t'(b));
  endfunction

  function automatic sat_t sat_scale(word_t a, logic [4:0] k);
    wide_t kw;
    kw = wide_t'({1'b0, k});
    return sat_wide(wide_t'(a) * kw);
  endfunction

  function automatic sat_t shift_sat(prod_t p, int sh);
    prod_t q;
    q = p >>> sh;
    return sat_wide(wide_t'(q));
  endfunction

  function automatic word_t coef_select(coef_t c, logic [1:0] kind, int step);
    word_t v;
    v = '0;
    case (step)
      0: begin
        case (kind)
          KIND_POS:   v = c.a3;
          KIND_FIRST: v = c.a4x4;
          default:    v = '0;
        endcase
      end
      1: begin
        case (kind)
          KIND_POS:    v = c.a2;
          KIND_FIRST:  v = c.a3x3;
          KIND_SECOND: v = c.a4x12;
          default:     v = '0;
        endcase
      end
      2: begin
        case (kind)
          KIND_POS:    v = c.a1;
          KIND_FIRST:  v = c.a2x2;
          KIND_SECOND: v = c.a3x6;
          default:     v = c.a4x24;
        endcase
      end
      default: begin
        case (kind)
          KIND_POS:    v = c.a0;
          KIND_FIRST:  v = c.a1;
          KIND_SECOND: v = c.a2x2;
          default:     v = c.a3x6;
        endcase
      end
    endcase
    return v;
  endfunction

endpackage

>>> src/qte_derive.sv
// ---------------------------------------------------------------------------
// qte_derive
// Coefficient sequencer: serial reciprocal of the duration, divide by three
// through a reciprocal multiply, then a shared multiplier for the products with
// the reciprocal, and a final step that scales the coefficients by constants.
// ---------------------------------------------------------------------------
module qte_derive #(
  parameter int FRAC_BITS = qte_pkg::FRAC_BITS
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           go,
  input  qte_pkg::cfg_t  cfg,
  output qte_pkg::coef_t coef,
  output logic           busy
);

  localparam int WB = qte_pkg::WORD_BITS;
  localparam int CNT_MAX = (2 * FRAC_BITS > WB) ? 2 * FRAC_BITS : WB;
  localparam int CNT_BITS = $clog2(CNT_MAX + 1);
  localparam logic [WB-1:0] DIV3_MUL = WB'(((64'd1 << (WB + 1)) + 64'd2) / 64'd3);

  typedef enum logic [3:0] {
    S_IDLE, S_RECIP, S_DIV3, S_M1, S_A3, S_M2, S_T4, S_A4, S_SCALE
  } state_t;

  state_t                state;
  logic [CNT_BITS-1:0]   cnt;
  logic [WB-1:0]         rem;
  logic [WB-1:0]         quo;
  qte_pkg::word_t        inv;
  logic [WB-1:0]         d3_mag;
  logic                  d3_neg;
  qte_pkg::word_t        s1;
  qte_pkg::word_t        m;
  qte_pkg::word_t        a2;
  qte_pkg::word_t        a3;
  qte_pkg::word_t        a4;
  qte_pkg::word_t        a2x2, a3x3, a3x6, a4x4, a4x12, a4x24;
  logic                  ov_first, ov_second, ov_third;

  logic [WB-1:0]         rem_sh;
  logic                  rem_ge;
  logic [WB-1:0]         quo_next;
  logic [2*WB-1:0]       d3_prod;
  logic [WB-2:0]         d3_quo;
  qte_pkg::word_t        x3;
  qte_pkg::word_t        half_d;
  qte_pkg::word_t        quarter_s;
  qte_pkg::sat_t         diff_ev, diff_ve, sum_ea, sum_ms, sum_mq;
  qte_pkg::word_t        mul_a;
  qte_pkg::prod_t        mul_p;
  qte_pkg::sat_t         mul_r;
  qte_pkg::sat_t         sc2, sc3, sc6, sc4, sc12, sc24;

  always_comb begin
    rem_sh   = {rem[WB-2:0], (cnt == CNT_BITS'(2 * FRAC_BITS))};
    rem_ge   = rem_sh >= {1'b0, cfg.duration};
    quo_next = quo | (WB'(1) << cnt);

    d3_prod = (2*WB)'(d3_mag) * (2*WB)'(DIV3_MUL);
    d3_quo  = d3_prod[2*WB-1:WB+1];

    x3 = qte_pkg::sat_sub(qte_pkg::sat_sub('0, cfg.end_accel).val,
                          qte_pkg::sat_add(cfg.start_accel, cfg.start_accel).val).val;

    diff_ev   = qte_pkg::sat_sub(cfg.end_velocity, cfg.start_velocity);
    diff_ve   = qte_pkg::sat_sub(cfg.start_velocity, cfg.end_velocity);
    half_d    = (diff_ve.val + qte_pkg::word_t'(diff_ve.val < 0)) >>> 1;
    sum_ea    = qte_pkg::sat_add(cfg.end_accel, cfg.start_accel);
    quarter_s = (sum_ea.val + ((sum_ea.val < 0) ? qte_pkg::word_t'(3) : qte_pkg::word_t'(0)))
                >>> 2;
    sum_ms    = qte_pkg::sat_add(m, s1);
    sum_mq    = qte_pkg::sat_add(m, quarter_s);

    case (state)
      S_M1:    mul_a = diff_ev.val;
      S_A3:    mul_a = sum_ms.val;
      S_M2:    mul_a = half_d;
      S_T4:    mul_a = sum_mq.val;
      default: mul_a = m;
    endcase
    mul_p = mul_a * inv;
    mul_r = qte_pkg::shift_sat(mul_p, FRAC_BITS);

    sc2  = qte_pkg::sat_scale(a2, 5'd2);
    sc3  = qte_pkg::sat_scale(a3, 5'd3);
    sc6  = qte_pkg::sat_scale(a3, 5'd6);
    sc4  = qte_pkg::sat_scale(a4, 5'd4);
    sc12 = qte_pkg::sat_scale(a4, 5'd12);
    sc24 = qte_pkg::sat_scale(a4, 5'd24);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      a2        <= '0;
      a3        <= '0;
      a4        <= '0;
      a2x2      <= '0;
      a3x3      <= '0;
      a3x6      <= '0;
      a4x4      <= '0;
      a4x12     <= '0;
      a4x24     <= '0;
      ov_first  <= 1'b0;
      ov_second <= 1'b0;
      ov_third  <= 1'b0;
    end else if (go) begin
      state <= S_RECIP;
      rem   <= '0;
      quo   <= '0;
      cnt   <= CNT_BITS'(2 * FRAC_BITS);
    end else begin
      unique case (state)
        S_IDLE: ;
        S_RECIP: begin
          rem <= rem_ge ? rem_sh - {1'b0, cfg.duration} : rem_sh;
          if (rem_ge && cnt >= CNT_BITS'(WB - 1)) begin
            inv <= qte_pkg::WORD_MAX;
          end else if (cnt == '0) begin
            inv <= qte_pkg::word_t'(rem_ge ? quo_next : quo);
          end
          if (rem_ge) begin
            quo <= quo_next;
          end
          if ((rem_ge && cnt >= CNT_BITS'(WB - 1)) || cnt == '0) begin
            state  <= S_DIV3;
            d3_neg <= x3 < 0;
            d3_mag <= (x3 < 0) ? WB'(-x3) : WB'(x3);
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_DIV3: begin
          s1    <= d3_neg ? -qte_pkg::word_t'({1'b0, d3_quo}) : qte_pkg::word_t'({1'b0, d3_quo});
          state <= S_M1;
        end
        S_M1: begin
          m     <= mul_r.val;
          state <= S_A3;
        end
        S_A3: begin
          a3    <= mul_r.val;
          state <= S_M2;
        end
        S_M2: begin
          m     <= mul_r.val;
          state <= S_T4;
        end
        S_T4: begin
          m     <= mul_r.val;
          state <= S_A4;
        end
        S_A4: begin
          a4    <= mul_r.val;
          a2    <= cfg.start_accel >>> 1;
          state <= S_SCALE;
        end
        S_SCALE: begin
          a2x2      <= sc2.val;
          a3x3      <= sc3.val;
          a3x6      <= sc6.val;
          a4x4      <= sc4.val;
          a4x12     <= sc12.val;
          a4x24     <= sc24.val;
          ov_first  <= sc4.ov | sc3.ov | sc2.ov;
          ov_second <= sc12.ov | sc6.ov | sc2.ov;
          ov_third  <= sc24.ov | sc6.ov;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    coef.a0        = cfg.start_position;
    coef.a1        = cfg.start_velocity;
    coef.a2        = a2;
    coef.a3        = a3;
    coef.a4        = a4;
    coef.a2x2      = a2x2;
    coef.a3x3      = a3x3;
    coef.a3x6      = a3x6;
    coef.a4x4      = a4x4;
    coef.a4x12     = a4x12;
    coef.a4x24     = a4x24;
    coef.ov_first  = ov_first;
    coef.ov_second = ov_second;
    coef.ov_third  = ov_third;
  end

endmodule

>>> src/qte_cell.sv
// ---------------------------------------------------------------------------
// qte_cell
// One Horner step: multiply the running value by time, then shift, saturate
// and add this step's coefficient. Two register stages.
// ---------------------------------------------------------------------------
module qte_cell #(
  parameter int FRAC_BITS = qte_pkg::FRAC_BITS,
  parameter int STEP      = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  qte_pkg::coef_t  coef,
  input  logic            in_valid,
  input  qte_pkg::stage_t in_stage,
  output logic            out_valid,
  output qte_pkg::stage_t out_stage
);

  logic            mid_valid;
  qte_pkg::stage_t mid_stage;
  qte_pkg::prod_t  prod;
  qte_pkg::sat_t   scaled;
  qte_pkg::sat_t   sum;
  qte_pkg::word_t  c;

  always_comb begin
    c      = qte_pkg::coef_select(coef, mid_stage.kind, STEP);
    scaled = qte_pkg::shift_sat(prod, FRAC_BITS);
    sum    = qte_pkg::sat_add(scaled.val, c);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      mid_valid <= in_valid;
      out_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    mid_stage      <= in_stage;
    prod           <= in_stage.r * in_stage.t;
    out_stage.kind <= mid_stage.kind;
    out_stage.t    <= mid_stage.t;
    out_stage.r    <= sum.val;
    out_stage.ov   <= mid_stage.ov | scaled.ov | sum.ov;
  end

endmodule

>>> src/quartic_trajectory_evaluator_unit.sv
// ---------------------------------------------------------------------------
// quartic_trajectory_evaluator_unit
// done rises once the request has passed the Horner cells, two stages per Horner cell.
// Throughput: one request per cycle while busy is low; the four cells run as a pipeline and
// results cannot be held off.
// A configuration write starts coefficient derivation (serial reciprocal first),
// busy high meanwhile; another write restarts it.
// Reset clears the registers to their defaults and the coefficients to zero.
// ---------------------------------------------------------------------------
module quartic_trajectory_evaluator_unit #(
  parameter int FRAC_BITS = qte_pkg::FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  qte_pkg::request_t             request,
  output logic                          done,
  output qte_pkg::result_t              result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [qte_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int NC = qte_pkg::NUM_CELLS;

  qte_pkg::cfg_t   cfg;
  qte_pkg::coef_t  coef;
  logic            wr;
  logic [2:0]      idx;
  logic            accept;
  logic            valid_chain [NC+1];
  qte_pkg::stage_t stage_chain [NC+1];

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[qte_pkg::ADDR_BITS-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_position <= '0;
      cfg.start_velocity <= '0;
      cfg.start_accel    <= '0;
      cfg.end_velocity   <= '0;
      cfg.end_accel      <= '0;
      cfg.duration       <= qte_pkg::DURATION_RESET;
    end else if (wr) begin
      unique case (idx)
        qte_pkg::REG_START_POSITION: cfg.start_position <= pwdata;
        qte_pkg::REG_START_VELOCITY: cfg.start_velocity <= pwdata;
        qte_pkg::REG_START_ACCEL:    cfg.start_accel    <= pwdata;
        qte_pkg::REG_END_VELOCITY:   cfg.end_velocity   <= pwdata;
        qte_pkg::REG_END_ACCEL:      cfg.end_accel      <= pwdata;
        qte_pkg::REG_DURATION:       cfg.duration       <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      qte_pkg::REG_START_POSITION: prdata = cfg.start_position;
      qte_pkg::REG_START_VELOCITY: prdata = cfg.start_velocity;
      qte_pkg::REG_START_ACCEL:    prdata = cfg.start_accel;
      qte_pkg::REG_END_VELOCITY:   prdata = cfg.end_velocity;
      qte_pkg::REG_END_ACCEL:      prdata = cfg.end_accel;
      qte_pkg::REG_DURATION:       prdata = {1'b0, cfg.duration};
      default:                     prdata = '0;
    endcase
  end

  qte_derive #(.FRAC_BITS(FRAC_BITS)) u_derive (
    .clk  (clk),
    .rst  (rst),
    .go   (wr),
    .cfg  (cfg),
    .coef (coef),
    .busy (busy)
  );

  assign accept = start & ~busy;

  always_comb begin
    valid_chain[0]      = accept;
    stage_chain[0].kind = request.kind;
    stage_chain[0].t    = request.time_point;
    stage_chain[0].r    = (request.kind == qte_pkg::KIND_POS) ? coef.a4 : '0;
    case (request.kind)
      qte_pkg::KIND_FIRST:  stage_chain[0].ov = coef.ov_first;
      qte_pkg::KIND_SECOND: stage_chain[0].ov = coef.ov_second;
      qte_pkg::KIND_THIRD:  stage_chain[0].ov = coef.ov_third;
      default:              stage_chain[0].ov = 1'b0;
    endcase
  end

  for (genvar i = 0; i < NC; i++) begin : g_cell
    qte_cell #(.FRAC_BITS(FRAC_BITS), .STEP(i)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .coef      (coef),
      .in_valid  (valid_chain[i]),
      .in_stage  (stage_chain[i]),
      .out_valid (valid_chain[i+1]),
      .out_stage (stage_chain[i+1])
    );
  end

  assign done            = valid_chain[NC];
  assign result.value    = stage_chain[NC].r;
  assign result.overflow = stage_chain[NC].ov;

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Quartic trajectory evaluator testbench
// Loads segment settings over the APB port, evaluates position and its three
// derivatives at chosen and random times, and compares every result and its saturation
// flag with a fixed-point Horner predictor or, in the first rows, a set value.
// ---------------------------------------------------------------------------
module tb;
  import qte_pkg::*;

  localparam longint WMAX = 64'sd2147483647;
  localparam longint WMIN = -64'sd2147483648;

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] t;
    bit          typed;
    logic [31:0] value;
    bit          ov;
    int          preset;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  request_t request = '0;
  logic done;
  result_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  longint seg_reg [6];
  longint coef_a2, coef_a3, coef_a4;
  bit sat_hit;
  result_t pending_results[$];
  int errors = 0;
  int n_requests = 0;
  int n_results = 0;
  int n_writes = 0;
  bit no_gaps = 1'b0;
  row_t rows [24];

  quartic_trajectory_evaluator_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .done(done), .result(result), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  function automatic longint clampw(longint v);
    if (v > WMAX) begin
      sat_hit = 1'b1;
      return WMAX;
    end
    if (v < WMIN) begin
      sat_hit = 1'b1;
      return WMIN;
    end
    return v;
  endfunction

  function automatic longint fx_mul(longint a, longint b, int sh);
    longint p;
    p = (a * b) >>> sh;
    return clampw(p);
  endfunction

  function automatic longint fx_add(longint a, longint b);
    return clampw(a + b);
  endfunction

  function automatic longint fx_sub(longint a, longint b);
    return clampw(a - b);
  endfunction

  function automatic longint inv_duration(longint d);
    longint q;
    if (d == 0) return WMAX;
    q = (64'sd1 <<< 32) / d;
    return (q > WMAX) ? WMAX : q;
  endfunction

  function automatic void derive_coefs();
    longint inv, t;
    inv = inv_duration(seg_reg[REG_DURATION]);
    coef_a2 = seg_reg[REG_START_ACCEL] >>> 1;
    t = fx_mul(fx_sub(seg_reg[REG_END_VELOCITY], seg_reg[REG_START_VELOCITY]), inv, FRAC_BITS);
    t = fx_add(t, fx_sub(fx_sub(0, seg_reg[REG_END_ACCEL]),
                         fx_mul(2, seg_reg[REG_START_ACCEL], 0)) / 3);
    coef_a3 = fx_mul(t, inv, FRAC_BITS);
    t = fx_sub(seg_reg[REG_START_VELOCITY], seg_reg[REG_END_VELOCITY]) / 2;
    t = fx_mul(t, inv, FRAC_BITS);
    t = fx_add(t, fx_add(seg_reg[REG_END_ACCEL], seg_reg[REG_START_ACCEL]) / 4);
    t = fx_mul(t, inv, FRAC_BITS);
    coef_a4 = fx_mul(t, inv, FRAC_BITS);
  endfunction

  function automatic result_t evaluate(logic [1:0] kind, logic [31:0] tp);
    longint t, r;
    result_t res;
    t = longint'($signed(tp));
    sat_hit = 1'b0;
    case (kind)
      KIND_POS: begin
        r = fx_add(coef_a3, fx_mul(t, coef_a4, FRAC_BITS));
        r = fx_add(fx_mul(r, t, FRAC_BITS), coef_a2);
        r = fx_add(fx_mul(r, t, FRAC_BITS), seg_reg[REG_START_VELOCITY]);
        r = fx_add(fx_mul(r, t, FRAC_BITS), seg_reg[REG_START_POSITION]);
      end
      KIND_FIRST: begin
        r = fx_add(fx_mul(3, coef_a3, 0), fx_mul(fx_mul(4, coef_a4, 0), t, FRAC_BITS));
        r = fx_add(fx_mul(2, coef_a2, 0), fx_mul(t, r, FRAC_BITS));
        r = fx_add(seg_reg[REG_START_VELOCITY], fx_mul(t, r, FRAC_BITS));
      end
      KIND_SECOND: begin
        r = fx_add(fx_mul(6, coef_a3, 0), fx_mul(fx_mul(12, coef_a4, 0), t, FRAC_BITS));
        r = fx_add(fx_mul(2, coef_a2, 0), fx_mul(t, r, FRAC_BITS));
      end
      default: begin
        r = fx_add(fx_mul(6, coef_a3, 0), fx_mul(fx_mul(24, coef_a4, 0), t, FRAC_BITS));
      end
    endcase
    res.value = word_t'(r);
    res.overflow = sat_hit;
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst && done) begin
      n_results++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result value=%h ov=%b", $time,
                 result.value, result.overflow);
      end else begin
        if (result.value !== pending_results[0].value ||
            result.overflow !== pending_results[0].overflow) begin
          errors++;
          $display("%0t: mismatch expected value=%h ov=%b actual value=%h ov=%b", $time,
                   pending_results[0].value, pending_results[0].overflow,
                   result.value, result.overflow);
        end
        void'(pending_results.pop_front());
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= ADDR_BITS'({idx, 2'b00});
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_DURATION) seg_reg[idx] = longint'(data[30:0]);
    else seg_reg[idx] = longint'($signed(data));
    derive_coefs();
    n_writes++;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic load_segment(logic [31:0] p, logic [31:0] v, logic [31:0] a,
                              logic [31:0] ev, logic [31:0] ea, logic [31:0] d);
    drain();
    write_reg(REG_START_POSITION, p);
    write_reg(REG_START_VELOCITY, v);
    write_reg(REG_START_ACCEL, a);
    write_reg(REG_END_VELOCITY, ev);
    write_reg(REG_END_ACCEL, ea);
    write_reg(REG_DURATION, d);
  endtask

  task automatic send_request(logic [1:0] kind, logic [31:0] tp, bit typed, result_t fixed);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    request <= '{kind: kind, time_point: tp};
    do @(posedge clk); while (busy);
    pending_results.push_back(typed ? fixed : evaluate(kind, tp));
    n_requests++;
  endtask

  function automatic logic [31:0] rand_q();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 8 * 65536)) - 4 * 65536);
    endcase
  endfunction

  function automatic logic [31:0] rand_time(longint d);
    case ($urandom_range(0, 7))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return (d > 0 && d < 32'h7fff0000) ? 32'($urandom_range(0, 32'(d))) : 32'h00010000;
    endcase
  endfunction

  function automatic logic [31:0] rand_duration();
    case ($urandom_range(0, 7))
      0: return $urandom();
      1: return $urandom_range(0, 2) == 0 ? 32'h0 : ($urandom_range(0, 1) ? 32'h1 : 32'h7fffffff);
      2: return 32'($urandom_range(1, 32'h8000));
      default: return 32'($urandom_range(32'h8000, 32'h50000));
    endcase
  endfunction

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    result_t fixed;
    logic [1:0] k;
    int count;
    rows[0]  = '{KIND_POS,    32'h00000000, 1, 32'h0, 0, 0};
    rows[1]  = '{KIND_FIRST,  32'h7fffffff, 1, 32'h0, 0, 0};
    rows[2]  = '{KIND_SECOND, 32'h80000000, 1, 32'h0, 0, 0};
    rows[3]  = '{KIND_THIRD,  32'hffffffff, 1, 32'h0, 0, 0};
    rows[4]  = '{KIND_POS,    32'h7fffffff, 1, 32'h0, 0, 0};
    rows[5]  = '{KIND_THIRD,  32'h80000000, 1, 32'h0, 0, 0};
    rows[6]  = '{KIND_POS,    32'h00010000, 0, 32'h0, 0, 1};
    rows[7]  = '{KIND_FIRST,  32'h00008000, 0, 32'h0, 0, 0};
    rows[8]  = '{KIND_SECOND, 32'h00020000, 0, 32'h0, 0, 0};
    rows[9]  = '{KIND_THIRD,  32'h00018000, 0, 32'h0, 0, 0};
    rows[10] = '{KIND_POS,    32'h7fffffff, 0, 32'h0, 0, 0};
    rows[11] = '{KIND_FIRST,  32'h80000000, 0, 32'h0, 0, 0};
    rows[12] = '{KIND_POS,    32'h00010000, 0, 32'h0, 0, 2};
    rows[13] = '{KIND_FIRST,  32'h00000001, 0, 32'h0, 0, 0};
    rows[14] = '{KIND_SECOND, 32'h80000000, 0, 32'h0, 0, 0};
    rows[15] = '{KIND_THIRD,  32'h7fffffff, 0, 32'h0, 0, 0};
    rows[16] = '{KIND_POS,    32'h00000000, 0, 32'h0, 0, 3};
    rows[17] = '{KIND_FIRST,  32'hffffffff, 0, 32'h0, 0, 0};
    rows[18] = '{KIND_SECOND, 32'h00010000, 0, 32'h0, 0, 0};
    rows[19] = '{KIND_THIRD,  32'h80000000, 0, 32'h0, 0, 0};
    rows[20] = '{KIND_POS,    32'h00001000, 0, 32'h0, 0, 4};
    rows[21] = '{KIND_FIRST,  32'h7fffffff, 0, 32'h0, 0, 0};
    rows[22] = '{KIND_SECOND, 32'hffff0000, 0, 32'h0, 0, 0};
    rows[23] = '{KIND_THIRD,  32'h00000000, 0, 32'h0, 0, 0};

    seg_reg = '{0, 0, 0, 0, 0, 65536};
    derive_coefs();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      case (rows[i].preset)
        1: load_segment(32'h00010000, 32'h00008000, 32'hffffc000,
                        32'h00020000, 32'h00002000, 32'h00020000);
        2: load_segment(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                        32'h80000000, 32'h80000000, 32'h00000000);
        3: load_segment(32'h80000000, 32'h80000000, 32'h80000000,
                        32'h7fffffff, 32'h7fffffff, 32'h00000001);
        4: load_segment(32'hffffffff, 32'h00000001, 32'hffffffff,
                        32'h00000000, 32'h00000001, 32'hffffffff);
        default: ;
      endcase
      fixed.value = rows[i].value;
      fixed.overflow = rows[i].ov;
      send_request(rows[i].kind, rows[i].t, rows[i].typed, fixed);
    end

    for (int ph = 0; ph < 12; ph++) begin
      load_segment(rand_q(), rand_q(), rand_q(), rand_q(), rand_q(), rand_duration());
      count = $urandom_range(140, 180);
      for (int n = 0; n < count; n++) begin
        if (n % 40 == 0) no_gaps = ($urandom_range(0, 2) == 0);
        if (n == count / 2) drain();
        k = 2'($urandom_range(0, 3));
        send_request(k, rand_time(seg_reg[REG_DURATION]), 0, fixed);
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Run covered %0d requests, %0d results, %0d register writes", n_requests,
             n_results, n_writes);
    $display("over all four evaluation kinds, including zero and tiny durations.");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
